@@ hdl/ph_two_point_median_filter_assert.svh @@
// Assertion macros used by the checker module.
`ifndef PH_TWO_POINT_MEDIAN_FILTER_ASSERT_SVH
`define PH_TWO_POINT_MEDIAN_FILTER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PH_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define PH_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

@@ hdl/phmf_pkg.sv @@
package phmf_pkg;
   localparam int CodeWidth = 12;
   localparam int PhWidth = 14;
   localparam logic [PhWidth-1:0] PhSeven = 14'd7168;
   localparam logic [PhWidth-1:0] PhMax = 14'd14336;
   localparam logic [11:0] PhSpanQ = 12'd3072;
   localparam logic [12:0] DefaultSpan = 13'd1241;

   localparam logic [2:0] RegNeutral = 3'd0;
   localparam logic [2:0] RegAcid = 3'd1;
   localparam logic [2:0] RegOffset = 3'd2;
   localparam logic [2:0] RegSafeLow = 3'd3;
   localparam logic [2:0] RegSafeHigh = 3'd4;

   // One queued word between front and back: converted and clamped pH.
   typedef struct packed {
      logic [PhWidth-1:0] ph;
   } conv_word_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_DIV,
      FE_DONE
   } fe_state_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_RANK,
      BE_OUT
   } be_state_type;
endpackage

@@ hdl/ph_two_point_median_filter.sv @@
// Channel   Direction  Word contents
// req_      in         tdata[11:0] adc_code
// rsp_      out        tdata[13:0] ph_value; tuser[0] window_full, tuser[1] in_safe_band
// csr_      in         index 0..4, data bits [13:0]
// The front end converts a code by loading it, dividing one quotient bit a cycle, then clamping.
// The back end ranks ring entries one per cycle, up to all WINDOW of them, once the ring is full.
// A one-word queue separates the two, so the front starts the next code while the back ranks.
// A new code is accepted only while the front end is idle and the queue is empty.
// An output register holds the result until rsp_tready; reset is synchronous and clears the
// ring to pH 7 and the registers to their defaults.
module ph_two_point_median_filter
   import phmf_pkg::*;
#(
   parameter int WINDOW = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // adc_code [11:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // ph_value [13:0]
   output logic [1:0]  rsp_tuser,   // window_full, in_safe_band
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_data
);
   logic [11:0] neutral_ff, acid_ff, offset_ff;
   logic [13:0] low_ff, high_ff;
   logic qv, qr, full, safe;
   conv_word_type qw;
   logic [PhWidth-1:0] ph;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         neutral_ff <= 12'd3102;
         acid_ff <= 12'd1861;
         offset_ff <= '0;
         low_ff <= 14'd6656;
         high_ff <= 14'd8704;
      end else if (csr_valid) begin
         unique case (csr_index)
            RegNeutral: neutral_ff <= csr_data[11:0];
            RegAcid: acid_ff <= csr_data[11:0];
            RegOffset: offset_ff <= csr_data[11:0];
            RegSafeLow: low_ff <= csr_data;
            RegSafeHigh: high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The front end is offered a code only while the queue is empty.
   logic fr_ready;
   logic fr_valid;
   assign fr_valid = req_tvalid && !qv;
   phmf_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(fr_valid), .in_ready(fr_ready), .in_code(req_tdata[11:0]),
      .neutral_code(neutral_ff), .acid_code(acid_ff), .ph_offset(offset_ff),
      .out_valid(qv), .out_ready(qr), .out_word(qw)
   );
   // Only accept when the queue is empty so a finished word never overwrites one.
   assign req_tready = fr_ready && !qv;

   phmf_back #(.WINDOW(WINDOW)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(qv), .in_ready(qr), .in_word(qw),
      .safe_low(low_ff), .safe_high(high_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_ph(ph), .out_full(full), .out_safe(safe)
   );

   assign rsp_tdata = {2'b00, ph};
   assign rsp_tuser = {safe, full};
endmodule

@@ hdl/phmf_front.sv @@
module phmf_front
   import phmf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [CodeWidth-1:0] in_code,
   input  logic [11:0]          neutral_code,
   input  logic [11:0]          acid_code,
   input  logic [11:0]          ph_offset,
   output logic                 out_valid,
   input  logic                 out_ready,
   output conv_word_type        out_word
);
   // Restoring division of |diff*3072| (24 bits) by |span| (13 bits), one bit a cycle.
   localparam int NumW = 24;
   fe_state_type state_ff, state_in;
   logic [NumW-1:0] quo_ff, quo_in;
   logic [13:0] rem_ff, rem_in;
   logic [12:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic [4:0] cnt_ff, cnt_in;
   conv_word_type word_ff, word_in;

   logic signed [12:0] span, diff;
   logic signed [24:0] prod;
   logic [13:0] trial;
   logic signed [25:0] sum;

   always_comb begin
      span = $signed({1'b0, neutral_code}) - $signed({1'b0, acid_code});
      if (span == 13'sd0) span = $signed(DefaultSpan);
      diff = $signed({1'b0, neutral_code}) - $signed({1'b0, in_code});
      prod = diff * $signed({1'b0, PhSpanQ});
      trial = {rem_ff[12:0], quo_ff[NumW-1]} - {1'b0, den_ff};
      sum = (neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff}))
            + $signed({12'd0, PhSeven})
            + $signed({{14{ph_offset[11]}}, ph_offset});
   end

   always_comb begin
      state_in = state_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      word_in = word_ff;
      in_ready = 1'b0;
      unique case (state_ff)
         FE_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               quo_in = prod[24] ? NumW'(-prod) : NumW'(prod);
               den_in = span[12] ? 13'(-span) : 13'(span);
               neg_in = prod[24] ^ span[12];
               rem_in = '0;
               cnt_in = '0;
               state_in = FE_DIV;
            end
         end
         FE_DIV: begin
            if (trial[13]) begin
               rem_in = {rem_ff[12:0], quo_ff[NumW-1]};
               quo_in = {quo_ff[NumW-2:0], 1'b0};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[NumW-2:0], 1'b1};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(NumW - 1)) state_in = FE_DONE;
         end
         FE_DONE: begin
            if (sum < 0) word_in.ph = '0;
            else if (sum > $signed({12'd0, PhMax})) word_in.ph = PhMax;
            else word_in.ph = sum[PhWidth-1:0];
            state_in = FE_IDLE;
         end
         default: state_in = FE_IDLE;
      endcase
   end

   // One-entry queue towards the back end.
   logic qv_ff, qv_in;
   always_comb begin
      qv_in = qv_ff;
      if (out_ready) qv_in = 1'b0;
      if (state_ff == FE_DONE) qv_in = 1'b1;
   end
   conv_word_type q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         qv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         qv_ff <= qv_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      word_ff <= word_in;
      if (state_ff == FE_DONE) q_ff <= word_in;
   end

   // A code is only offered while the queue is empty, so a finished word always finds it free.
   assign out_valid = qv_ff;
   assign out_word = q_ff;
endmodule

@@ hdl/phmf_back.sv @@
module phmf_back
   import phmf_pkg::*;
#(
   parameter int WINDOW = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  conv_word_type      in_word,
   input  logic [PhWidth-1:0] safe_low,
   input  logic [PhWidth-1:0] safe_high,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [PhWidth-1:0] out_ph,
   output logic               out_full,
   output logic               out_safe
);
   localparam int SW = $clog2(WINDOW);
   localparam int CW = $clog2(WINDOW + 1);
   be_state_type state_ff, state_in;
   logic [PhWidth-1:0] ring_ff [WINDOW];
   logic [SW-1:0] slot_ff;
   logic filled_ff;
   logic [SW-1:0] cand_ff;
   logic [PhWidth-1:0] res_ff;
   logic rv_ff;
   logic [CW-1:0] less, lesseq;
   logic [PhWidth-1:0] cv;
   logic last;

   // Rank selection: candidate i is the median when less < W/2+1 <= lesseq.
   always_comb begin
      cv = ring_ff[cand_ff];
      less = '0;
      lesseq = '0;
      for (int i = 0; i < WINDOW; i++) begin
         if (ring_ff[i] < cv) less = less + CW'(1);
         if (ring_ff[i] <= cv) lesseq = lesseq + CW'(1);
      end
   end
   assign last = (slot_ff == SW'(WINDOW - 1));

   always_comb begin
      state_in = state_ff;
      in_ready = 1'b0;
      unique case (state_ff)
         BE_IDLE: begin
            in_ready = !rv_ff || out_ready;
            if (in_valid && in_ready) state_in = (filled_ff || last) ? BE_RANK : BE_OUT;
         end
         BE_RANK: begin
            if (less <= CW'(WINDOW / 2) && lesseq > CW'(WINDOW / 2)) state_in = BE_OUT;
         end
         BE_OUT: state_in = BE_IDLE;
         default: state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         slot_ff <= '0;
         filled_ff <= 1'b0;
         rv_ff <= 1'b0;
         for (int i = 0; i < WINDOW; i++) ring_ff[i] <= PhSeven;
      end else begin
         state_ff <= state_in;
         if (rv_ff && out_ready) rv_ff <= 1'b0;
         if (state_ff == BE_IDLE && in_valid && in_ready) begin
            ring_ff[slot_ff] <= in_word.ph;
            res_ff <= in_word.ph;
            cand_ff <= '0;
            slot_ff <= last ? '0 : slot_ff + SW'(1);
            if (last) filled_ff <= 1'b1;
         end
         if (state_ff == BE_RANK) begin
            res_ff <= cv;
            cand_ff <= cand_ff + SW'(1);
         end
         if (state_ff == BE_OUT) rv_ff <= 1'b1;
      end
   end

   assign out_valid = rv_ff;
   assign out_ph = res_ff;
   assign out_full = filled_ff;
   assign out_safe = (res_ff >= safe_low) && (res_ff <= safe_high);
endmodule

@@ hdl/phmf_checker.sv @@
module phmf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
`include "ph_two_point_median_filter_assert.svh"
   `PH_ASSERT_IMP(a_range, clock, reset, rsp_tvalid, rsp_tdata <= 16'd14336, "pH out of range")
   `PH_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
   `PH_ASSERT_NEXT(a_full, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tvalid || rsp_tuser[0], "window full lost")
endmodule

bind ph_two_point_median_filter phmf_checker u_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
